// ===== rtl/core/tlet_pkg.sv =====
`default_nettype none

package tlet_pkg;

  localparam int LIGHT_LIMIT = 32;
  localparam int EVENT_LIMIT = 128;
  localparam int EVENTS_DEF = 32;
  localparam int LIGHTS_DEF = 32;

  localparam int OP_W    = 3;
  localparam int ID_W    = 8;
  localparam int DAY_W   = 4;
  localparam int MIN_W   = 11;
  localparam int OFS_W   = 7;
  localparam int WDAY_W  = 3;
  localparam int LIGHT_W = $clog2(LIGHT_LIMIT);
  localparam int SUM_W   = MIN_W + 2;

  typedef enum logic [OP_W-1:0] {
    OP_ON     = 3'd0,
    OP_OFF    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_RANDOM = 3'd3,
    OP_TICK   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ID_RANGE = 2'd1,
    ST_FULL     = 2'd2,
    ST_NO_EVENT = 2'd3
  } status_t;

  localparam logic [DAY_W-1:0] DAY_EVERY   = 4'd7;
  localparam logic [DAY_W-1:0] DAY_WORK    = 4'd8;
  localparam logic [DAY_W-1:0] DAY_WEEKEND = 4'd9;
  localparam logic [WDAY_W-1:0] WDAY_SUN   = 3'd0;
  localparam logic [WDAY_W-1:0] WDAY_MON   = 3'd1;
  localparam logic [WDAY_W-1:0] WDAY_FRI   = 3'd5;
  localparam logic [WDAY_W-1:0] WDAY_SAT   = 3'd6;

  typedef struct packed {
    logic [LIGHT_W-1:0] light;
    logic [DAY_W-1:0]   day;
    logic [MIN_W-1:0]   minute;
    logic               turns_on;
    logic [OFS_W-1:0]   offset;
  } slot_t;

  typedef struct packed {
    logic               strobe;
    status_t            status;
    logic               cmd_valid;
    logic [LIGHT_W-1:0] light;
    logic               cmd_on;
    logic               last;
  } res_t;

  function automatic logic day_match(input logic [DAY_W-1:0] code,
                                     input logic [WDAY_W-1:0] today);
    logic m;
    begin
      if (code == DAY_EVERY) begin
        m = 1'b1;
      end else if (code == DAY_WORK) begin
        m = (today >= WDAY_MON) && (today <= WDAY_FRI);
      end else if (code == DAY_WEEKEND) begin
        m = (today == WDAY_SUN) || (today == WDAY_SAT);
      end else begin
        m = !code[DAY_W-1] && (code[WDAY_W-1:0] == today);
      end
      return m;
    end
  endfunction

  function automatic logic is_due(input logic [MIN_W-1:0] now,
                                  input logic [MIN_W-1:0] minute,
                                  input logic [OFS_W-1:0] offset);
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] nw;
    begin
      sum = $signed({2'b00, minute}) + $signed({{(SUM_W-OFS_W){offset[OFS_W-1]}}, offset});
      nw  = $signed({2'b00, now});
      return nw >= sum;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tlet_slot_ram.sv =====
`default_nettype none

module tlet_slot_ram import tlet_pkg::*; #(
  parameter int EVENTS = EVENTS_DEF,
  localparam int IDX_W = (EVENTS > 1) ? $clog2(EVENTS) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire slot_t            wr_data,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output slot_t                 rd_data
);

  slot_t mem [EVENTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tlet_seq.sv =====
`default_nettype none

module tlet_seq import tlet_pkg::*; #(
  parameter int EVENTS = EVENTS_DEF,
  parameter int LIGHTS = LIGHTS_DEF,
  localparam int IDX_W = (EVENTS > 1) ? $clog2(EVENTS) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [OP_W-1:0]     in_operation,
  input  wire logic signed [ID_W-1:0] in_light_id,
  input  wire logic [DAY_W-1:0]    in_day_code,
  input  wire logic [MIN_W-1:0]    in_event_minute,
  input  wire logic signed [OFS_W-1:0] in_random_offset,
  input  wire logic [MIN_W-1:0]    in_now_minute,
  input  wire logic [WDAY_W-1:0]   in_now_day,
  output logic                     wr_en,
  output logic [IDX_W-1:0]         wr_addr,
  output slot_t                    wr_data,
  output logic                     rd_en,
  output logic [IDX_W-1:0]         rd_addr,
  input  wire slot_t               rd_data,
  output res_t                     res
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(EVENTS - 1);

  state_t                  state_r, state_nxt;
  op_t                     op_r, op_nxt;
  logic [ID_W-1:0]         id_r, id_nxt;
  logic [DAY_W-1:0]        day_r, day_nxt;
  logic [MIN_W-1:0]        min_r, min_nxt;
  logic [OFS_W-1:0]        ofs_r, ofs_nxt;
  logic [MIN_W-1:0]        now_min_r, now_min_nxt;
  logic [WDAY_W-1:0]       now_day_r, now_day_nxt;
  status_t                 st_r, st_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic                    issue_r, issue_nxt;
  logic                    pend_r, pend_nxt;
  logic [IDX_W-1:0]        pidx_r, pidx_nxt;
  logic [EVENTS-1:0]       valid_r, valid_nxt;

  logic id_ok;
  logic key_hit;
  logic tick_hit;

  assign busy    = (state_r != S_IDLE);
  assign rd_addr = idx_r;
  assign rd_en   = (state_r == S_SCAN) && issue_r;

  assign id_ok = !in_light_id[ID_W-1] && ($unsigned(in_light_id) < ID_W'(LIGHTS));

  assign key_hit = valid_r[pidx_r] && !id_r[ID_W-1] && (id_r[ID_W-2:LIGHT_W] == '0) &&
                   (id_r[LIGHT_W-1:0] == rd_data.light) && (day_r == rd_data.day) &&
                   (min_r == rd_data.minute);

  assign tick_hit = valid_r[pidx_r] && day_match(rd_data.day, now_day_r) &&
                    is_due(now_min_r, rd_data.minute, rd_data.offset);

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    id_nxt      = id_r;
    day_nxt     = day_r;
    min_nxt     = min_r;
    ofs_nxt     = ofs_r;
    now_min_nxt = now_min_r;
    now_day_nxt = now_day_r;
    st_nxt      = st_r;
    idx_nxt     = idx_r;
    issue_nxt   = issue_r;
    pend_nxt    = 1'b0;
    pidx_nxt    = idx_r;
    valid_nxt   = valid_r;
    wr_en       = 1'b0;
    wr_addr     = idx_r;
    wr_data     = '{light: id_r[LIGHT_W-1:0], day: day_r, minute: min_r,
                    turns_on: (op_r == OP_ON), offset: '0};
    res         = '{strobe: 1'b0, status: ST_OK, cmd_valid: 1'b0, light: '0,
                    cmd_on: 1'b0, last: 1'b0};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt      = op_t'(in_operation);
          id_nxt      = in_light_id;
          day_nxt     = in_day_code;
          min_nxt     = in_event_minute;
          ofs_nxt     = in_random_offset;
          now_min_nxt = in_now_minute;
          now_day_nxt = in_now_day;
          idx_nxt     = '0;
          issue_nxt   = 1'b1;
          state_nxt   = S_SCAN;
          case (op_t'(in_operation))
            OP_ON, OP_OFF: begin
              st_nxt = ST_FULL;
              if (!id_ok) begin
                st_nxt    = ST_ID_RANGE;
                state_nxt = S_FINISH;
              end
            end
            OP_REMOVE: st_nxt = ST_NO_EVENT;
            OP_RANDOM, OP_TICK: st_nxt = ST_OK;
            default: begin
              st_nxt    = ST_OK;
              state_nxt = S_FINISH;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (op_r == OP_ON || op_r == OP_OFF) begin
          if (!valid_r[idx_r]) begin
            wr_en            = 1'b1;
            valid_nxt[idx_r] = 1'b1;
            st_nxt           = ST_OK;
            state_nxt        = S_FINISH;
          end else if (idx_r == LAST_IDX) begin
            state_nxt = S_FINISH;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          if (issue_r) begin
            pend_nxt = 1'b1;
            if (idx_r == LAST_IDX) begin
              issue_nxt = 1'b0;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
          if (pend_r) begin
            if (pidx_r == LAST_IDX) begin
              state_nxt = S_FINISH;
            end
            case (op_r)
              OP_REMOVE: begin
                if (key_hit) begin
                  valid_nxt[pidx_r] = 1'b0;
                  st_nxt            = ST_OK;
                  state_nxt         = S_FINISH;
                end
              end
              OP_RANDOM: begin
                if (key_hit) begin
                  wr_en          = 1'b1;
                  wr_addr        = pidx_r;
                  wr_data        = rd_data;
                  wr_data.offset = ofs_r;
                end
              end
              default: begin
                if (tick_hit) begin
                  res = '{strobe: 1'b1, status: ST_OK, cmd_valid: 1'b1,
                          light: rd_data.light, cmd_on: rd_data.turns_on, last: 1'b0};
                end
              end
            endcase
          end
        end
      end
      S_FINISH: begin
        res       = '{strobe: 1'b1, status: st_r, cmd_valid: 1'b0, light: '0,
                      cmd_on: 1'b0, last: 1'b1};
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      pend_r  <= 1'b0;
      issue_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
      issue_r <= issue_nxt;
    end
    op_r      <= op_nxt;
    id_r      <= id_nxt;
    day_r     <= day_nxt;
    min_r     <= min_nxt;
    ofs_r     <= ofs_nxt;
    now_min_r <= now_min_nxt;
    now_day_r <= now_day_nxt;
    st_r      <= st_nxt;
    idx_r     <= idx_nxt;
    pidx_r    <= pidx_nxt;
  end

  a_cmd_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    res.strobe && res.cmd_valid |-> op_r == OP_TICK)
    else $error("light command outside a wake-up tick");

  a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> state_r == S_SCAN && (op_r == OP_ON || op_r == OP_OFF || op_r == OP_RANDOM))
    else $error("slot memory written outside a scan");

  a_schedule_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && wr_en && (op_r == OP_ON || op_r == OP_OFF) |=> valid_r[$past(wr_addr)])
    else $error("scheduled slot not marked valid");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    res.strobe && res.last |=> state_r == S_IDLE)
    else $error("final result did not end the item");

endmodule

`default_nettype wire

// ===== rtl/core/timed_light_event_table_top.sv =====
// Channel   Ports                                          Handshake
// input     in_operation .. in_now_day                     start high, busy low
// result    out_status .. out_last                         out_strobe, one cycle
//
// Schedule scans the valid flags one slot a cycle, and its result passes through
// the output register. Remove, randomize and tick stream the slot memory one
// entry a cycle through its registered read, and their results pass through the
// output register too; a tick shows one command per due slot.
// Reset clears the valid flags synchronously; the slot memory itself is not cleared.
// The receiver cannot stall, so results leave at the pace the scan makes them.
`default_nettype none

module timed_light_event_table_top import tlet_pkg::*; #(
  parameter int EVENTS = EVENTS_DEF,
  parameter int LIGHTS = LIGHTS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [OP_W-1:0]         in_operation,
  input  wire logic signed [ID_W-1:0]  in_light_id,
  input  wire logic [DAY_W-1:0]        in_day_code,
  input  wire logic [MIN_W-1:0]        in_event_minute,
  input  wire logic signed [OFS_W-1:0] in_random_offset,
  input  wire logic [MIN_W-1:0]        in_now_minute,
  input  wire logic [WDAY_W-1:0]       in_now_day,
  output logic                         out_strobe,
  output logic [1:0]                   out_status,
  output logic                         out_command_valid,
  output logic [LIGHT_W-1:0]           out_command_light,
  output logic                         out_command_on,
  output logic                         out_last
);

  localparam int IDX_W = (EVENTS > 1) ? $clog2(EVENTS) : 1;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_t            wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  slot_t            rd_data;
  res_t             res;
  res_t             res_r;

  tlet_slot_ram #(.EVENTS(EVENTS)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tlet_seq #(.EVENTS(EVENTS), .LIGHTS(LIGHTS)) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_light_id      (in_light_id),
    .in_day_code      (in_day_code),
    .in_event_minute  (in_event_minute),
    .in_random_offset (in_random_offset),
    .in_now_minute    (in_now_minute),
    .in_now_day       (in_now_day),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.strobe <= 1'b0;
    end else begin
      res_r.strobe <= res.strobe;
    end
    res_r.status    <= res.status;
    res_r.cmd_valid <= res.cmd_valid;
    res_r.light     <= res.light;
    res_r.cmd_on    <= res.cmd_on;
    res_r.last      <= res.last;
  end

  assign out_strobe        = res_r.strobe;
  assign out_status        = res_r.status;
  assign out_command_valid = res_r.cmd_valid;
  assign out_command_light = res_r.light;
  assign out_command_on    = res_r.cmd_on;
  assign out_last          = res_r.last;

endmodule

`default_nettype wire
